// ===== rtl/ppt_pkg.sv =====
package ppt_pkg;

  // default sizes
  localparam int CAPACITY_DEF    = 64;
  localparam int HANDLE_BITS_DEF = 16;

  // field widths
  localparam int MODE_W     = 3;
  localparam int POS_W      = 8;
  localparam int SONG_W     = 16;
  localparam int STATUS_W   = 2;
  localparam int COUNT_W    = 7;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 32;

  // operation codes
  localparam logic [MODE_W-1:0] MODE_INS_FRONT = 3'd0;
  localparam logic [MODE_W-1:0] MODE_INS_BACK  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_DELETE    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_READ      = 3'd3;
  localparam logic [MODE_W-1:0] MODE_WRITE     = 3'd4;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_MOD_WAIT,
    S_ACCESS,
    S_READ_CAP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_FINISH
  } state_t;

  // remainder unit status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== rtl/positional_playlist_table.sv =====
// channel | dir | tdata (low bit up)                           | tuser
// in_     | in  | position[7:0], song_handle[23:8]             | mode[2:0]
// out_    | out | status[1:0], read_handle[17:2], count[24:18] | -
//
// one item at a time; the store is a one-write, one-read memory, read data registered
// insert: written in decode; read/overwrite: waits on the remainder unit for a nonzero position
// delete at position p: entries behind p move down, one entry moved per cycle; none move at the tail
// rst_n is synchronous: list is emptied, head set to zero, store contents left as they are
// a finished result sits in the output register; a stalled out_ waits only when the next
// result is ready too
module positional_playlist_table #(
  parameter int CAPACITY    = ppt_pkg::CAPACITY_DEF,
  parameter int HANDLE_BITS = ppt_pkg::HANDLE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [ppt_pkg::IN_DATA_W-1:0]  in_tdata,   // position, song_handle
  input  logic [ppt_pkg::MODE_W-1:0]     in_tuser,   // mode
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [ppt_pkg::OUT_DATA_W-1:0] out_tdata   // status, read_handle, entry_count
);

  localparam int AW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = ((CW > ppt_pkg::POS_W) ? CW : ppt_pkg::POS_W) + 1;
  localparam logic [ppt_pkg::POS_W-1:0] POS_ONE = 1;

  ppt_pkg::state_t state_r, state_nxt;

  logic [ppt_pkg::MODE_W-1:0]     mode_r, mode_nxt;
  logic [ppt_pkg::POS_W-1:0]      pos_r, pos_nxt;
  logic [HANDLE_BITS-1:0]         hnd_r, hnd_nxt;
  logic [AW-1:0]                  head_r, head_nxt;
  logic [CW-1:0]                  len_r, len_nxt;
  logic [CW-1:0]                  idx_r, idx_nxt;
  logic [CW-1:0]                  off_r, off_nxt;
  logic [ppt_pkg::STATUS_W-1:0]   status_r, status_nxt;
  logic [ppt_pkg::SONG_W-1:0]     rdh_r, rdh_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [ppt_pkg::OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  // entry store
  logic [HANDLE_BITS-1:0] mem [CAPACITY];
  logic [HANDLE_BITS-1:0] rd_data_r;
  logic                   mem_we, mem_re;
  logic [AW-1:0]          mem_wa, mem_ra;
  logic [HANDLE_BITS-1:0] mem_wd;

  // remainder unit
  logic                  div_start;
  ppt_pkg::div_stat_t    div_stat;
  logic [CW-1:0]         div_rem;
  logic [ppt_pkg::POS_W-1:0] pos_m1;

  logic [31:0]     song_wide, rd_wide, len_wide;
  logic [CMPW-1:0] len_ext, pos_ext, cap_ext, idx2_ext;
  logic            list_empty, list_full, pos_bad;
  logic [AW-1:0]   head_dec;
  logic [CW:0]     idx_p1, idx_p2;
  logic            out_free;

  // ring slot of list entry k, k below CAPACITY
  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] head, input logic [CW:0] k);
    logic [CW+1:0] s;
    s = (CW+2)'(head) + (CW+2)'(k);
    if (s >= (CW+2)'(CAPACITY)) begin
      s = s - (CW+2)'(CAPACITY);
    end
    return s[AW-1:0];
  endfunction

  assign song_wide  = 32'(in_tdata[23:8]);
  assign rd_wide    = 32'(rd_data_r);
  assign len_wide   = 32'(len_r);
  assign len_ext    = CMPW'(len_r);
  assign pos_ext    = CMPW'(pos_r);
  assign cap_ext    = CMPW'(CAPACITY);
  assign idx_p1     = {1'b0, idx_r} + (CW+1)'(1);
  assign idx_p2     = {1'b0, idx_r} + (CW+1)'(2);
  assign idx2_ext   = CMPW'(idx_p2);
  assign list_empty = (len_r == '0);
  assign list_full  = (len_ext >= cap_ext);
  assign pos_bad    = (pos_r == '0) || (pos_ext > len_ext);
  assign head_dec   = (head_r == '0) ? AW'(CAPACITY - 1) : (head_r - AW'(1));
  assign pos_m1     = pos_r - POS_ONE;
  assign out_free   = !out_valid_r || out_tready;

  ppt_mod #(
    .CNT_W(CW)
  ) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (pos_m1),
    .divisor  (len_r),
    .stat     (div_stat),
    .remainder(div_rem)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ppt_pkg::S_IDLE: begin
        if (in_tvalid) state_nxt = ppt_pkg::S_DECODE;
      end
      ppt_pkg::S_DECODE: begin
        case (mode_r)
          ppt_pkg::MODE_DELETE: begin
            if (!list_empty && !pos_bad && (pos_ext < len_ext)) begin
              state_nxt = ppt_pkg::S_SHIFT_RD;
            end else begin
              state_nxt = ppt_pkg::S_FINISH;
            end
          end
          ppt_pkg::MODE_READ, ppt_pkg::MODE_WRITE: begin
            if (list_empty) begin
              state_nxt = ppt_pkg::S_FINISH;
            end else if (pos_r == '0) begin
              state_nxt = ppt_pkg::S_ACCESS;
            end else begin
              state_nxt = ppt_pkg::S_MOD_WAIT;
            end
          end
          default: state_nxt = ppt_pkg::S_FINISH;
        endcase
      end
      ppt_pkg::S_MOD_WAIT: begin
        if (div_stat.done) state_nxt = ppt_pkg::S_ACCESS;
      end
      ppt_pkg::S_ACCESS: begin
        state_nxt = (mode_r == ppt_pkg::MODE_READ) ? ppt_pkg::S_READ_CAP : ppt_pkg::S_FINISH;
      end
      ppt_pkg::S_READ_CAP: state_nxt = ppt_pkg::S_FINISH;
      ppt_pkg::S_SHIFT_RD: state_nxt = ppt_pkg::S_SHIFT_WR;
      ppt_pkg::S_SHIFT_WR: begin
        if (idx2_ext >= len_ext) state_nxt = ppt_pkg::S_FINISH;
      end
      ppt_pkg::S_FINISH: begin
        if (out_free) state_nxt = ppt_pkg::S_IDLE;
      end
      default: state_nxt = ppt_pkg::S_IDLE;
    endcase
  end

  // datapath and store access
  always_comb begin
    mode_nxt      = mode_r;
    pos_nxt       = pos_r;
    hnd_nxt       = hnd_r;
    head_nxt      = head_r;
    len_nxt       = len_r;
    idx_nxt       = idx_r;
    off_nxt       = off_r;
    status_nxt    = status_r;
    rdh_nxt       = rdh_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_wa        = '0;
    mem_wd        = hnd_r;
    mem_re        = 1'b0;
    mem_ra        = '0;
    div_start     = 1'b0;
    case (state_r)
      ppt_pkg::S_IDLE: begin
        if (in_tvalid) begin
          mode_nxt   = in_tuser;
          pos_nxt    = in_tdata[7:0];
          hnd_nxt    = song_wide[HANDLE_BITS-1:0];
          status_nxt = ppt_pkg::ST_OK;
          rdh_nxt    = '0;
        end
      end
      ppt_pkg::S_DECODE: begin
        case (mode_r)
          ppt_pkg::MODE_INS_FRONT: begin
            if (list_full) begin
              status_nxt = ppt_pkg::ST_FULL;
            end else begin
              head_nxt = head_dec;
              mem_we   = 1'b1;
              mem_wa   = head_dec;
              len_nxt  = len_r + CW'(1);
            end
          end
          ppt_pkg::MODE_INS_BACK: begin
            if (list_full) begin
              status_nxt = ppt_pkg::ST_FULL;
            end else begin
              mem_we  = 1'b1;
              mem_wa  = slot_of(head_r, {1'b0, len_r});
              len_nxt = len_r + CW'(1);
            end
          end
          ppt_pkg::MODE_DELETE: begin
            if (list_empty) begin
              status_nxt = ppt_pkg::ST_EMPTY;
            end else if (pos_bad) begin
              status_nxt = ppt_pkg::ST_BADPOS;
            end else begin
              idx_nxt = CW'(pos_ext - CMPW'(1));
              // last entry removed: nothing to move
              if (pos_ext == len_ext) begin
                len_nxt = len_r - CW'(1);
                if (len_r == CW'(1)) head_nxt = '0;
              end
            end
          end
          ppt_pkg::MODE_READ, ppt_pkg::MODE_WRITE: begin
            if (list_empty) begin
              status_nxt = ppt_pkg::ST_EMPTY;
            end else if (pos_r == '0) begin
              off_nxt = '0;
            end else begin
              div_start = 1'b1;
            end
          end
          default: ;
        endcase
      end
      ppt_pkg::S_MOD_WAIT: begin
        if (div_stat.done) off_nxt = div_rem;
      end
      ppt_pkg::S_ACCESS: begin
        if (mode_r == ppt_pkg::MODE_READ) begin
          mem_re = 1'b1;
          mem_ra = slot_of(head_r, {1'b0, off_r});
        end else begin
          mem_we = 1'b1;
          mem_wa = slot_of(head_r, {1'b0, off_r});
        end
      end
      ppt_pkg::S_READ_CAP: begin
        rdh_nxt = rd_wide[ppt_pkg::SONG_W-1:0];
      end
      // fetch the entry behind the deleted one
      ppt_pkg::S_SHIFT_RD: begin
        mem_re = 1'b1;
        mem_ra = slot_of(head_r, idx_p1);
      end
      // move one entry down, fetch the next
      ppt_pkg::S_SHIFT_WR: begin
        mem_we  = 1'b1;
        mem_wa  = slot_of(head_r, {1'b0, idx_r});
        mem_wd  = rd_data_r;
        idx_nxt = idx_p1[CW-1:0];
        if (idx2_ext < len_ext) begin
          mem_re = 1'b1;
          mem_ra = slot_of(head_r, idx_p2);
        end else begin
          len_nxt = len_r - CW'(1);
        end
      end
      ppt_pkg::S_FINISH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = ppt_pkg::OUT_DATA_W'({len_wide[ppt_pkg::COUNT_W-1:0], rdh_r, status_r});
        end
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ppt_pkg::S_IDLE;
      head_r      <= '0;
      len_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      len_r       <= len_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    mode_r     <= mode_nxt;
    pos_r      <= pos_nxt;
    hnd_r      <= hnd_nxt;
    idx_r      <= idx_nxt;
    off_r      <= off_nxt;
    status_r   <= status_nxt;
    rdh_r      <= rdh_nxt;
    out_data_r <= out_data_nxt;
  end

  // store write port
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
  end

  // store read port, registered
  always_ff @(posedge clk) begin
    if (mem_re) rd_data_r <= mem[mem_ra];
  end

  assign in_tready  = (state_r == ppt_pkg::S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== rtl/ppt_mod.sv =====
module ppt_mod #(
  parameter int CNT_W = ppt_pkg::COUNT_W
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [ppt_pkg::POS_W-1:0] dividend,
  input  logic [CNT_W-1:0]         divisor,
  output ppt_pkg::div_stat_t       stat,
  output logic [CNT_W-1:0]         remainder
);

  localparam int RW = ((CNT_W > ppt_pkg::POS_W) ? CNT_W : ppt_pkg::POS_W) + 1;
  localparam int SW = $clog2(ppt_pkg::POS_W);

  logic                      busy_r, busy_nxt;
  logic                      done_r, done_nxt;
  logic [SW-1:0]             step_r, step_nxt;
  logic [ppt_pkg::POS_W-1:0] quo_r, quo_nxt;
  logic [RW-1:0]             rem_r, rem_nxt;
  logic [RW-1:0]             dvs_r, dvs_nxt;
  logic [RW-1:0]             rem_sh;
  logic [RW-1:0]             rem_sub;

  // one restoring step: bring down the next dividend bit, subtract if it fits
  assign rem_sh  = {rem_r[RW-2:0], quo_r[ppt_pkg::POS_W-1]};
  assign rem_sub = rem_sh - dvs_r;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = SW'(ppt_pkg::POS_W - 1);
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = RW'(divisor);
    end else if (busy_r) begin
      rem_nxt = (rem_sh >= dvs_r) ? rem_sub : rem_sh;
      quo_nxt = quo_r << 1;
      if (step_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        step_nxt = step_r - SW'(1);
      end
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    dvs_r  <= dvs_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign remainder = rem_r[CNT_W-1:0];

endmodule

// ===== rtl/ppt_chk.sv =====
module ppt_chk #(
  parameter int CAPACITY = ppt_pkg::CAPACITY_DEF
) (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [ppt_pkg::OUT_DATA_W-1:0] out_tdata
);

  localparam logic [ppt_pkg::COUNT_W-1:0] CNT_FULL = ppt_pkg::COUNT_W'(CAPACITY);

  // one item at a time: busy right after an accepted beat
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while previous item in work");

  // a full report carries the capacity as count
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[1:0] == ppt_pkg::ST_FULL) |-> (out_tdata[24:18] == CNT_FULL))
    else $error("full status with count below capacity");

  // an empty report carries a zero count
  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[1:0] == ppt_pkg::ST_EMPTY) |-> (out_tdata[24:18] == '0))
    else $error("empty status with nonzero count");

  // handle only on a successful read
  a_handle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[1:0] != ppt_pkg::ST_OK) |-> (out_tdata[17:2] == '0))
    else $error("handle reported with error status");

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed under stall");

endmodule

bind positional_playlist_table ppt_chk #(.CAPACITY(CAPACITY)) u_ppt_chk (.*);
